// ===== src/utf8dec_pkg.sv =====
`timescale 1ns / 1ps

package utf8dec_pkg;

    // Unit values
    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [15:0] HIGH_SURR   = 16'hD800;
    localparam logic [15:0] LOW_SURR    = 16'hDC00;

    // Sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    localparam int MAX_UNITS = 4;

    // Units caused by one input byte, oldest in slot 0
    typedef struct packed {
        logic [2:0]             cnt;
        logic [3:0][15:0]       units;
    } t_dec_rec;

endpackage

// ===== src/utf8dec_if.sv =====
`timescale 1ns / 1ps

// Byte channel
interface utf8dec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Code unit channel
interface utf8dec_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;
    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

// ===== src/utf8dec_front.sv =====
`timescale 1ns / 1ps

module utf8dec_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    output logic                  o_ready,
    output logic                  o_push,
    output utf8dec_pkg::t_dec_rec o_rec,
    input  logic                  i_push_ready
);

    logic [20:0] r_partial, n_partial;
    logic [2:0]  r_expected, n_expected;
    logic [2:0]  r_held, n_held;

    logic        is_cont;
    logic        seq_open;
    logic [20:0] cp_next;
    logic [2:0]  held_inc;
    logic [20:0] supp;
    logic [1:0]  rep;
    logic [1:0]  tcnt;
    logic [15:0] t0, t1;
    logic        accept;

    assign is_cont  = (i_byte[7:6] == 2'b10);
    assign seq_open = (r_expected != utf8dec_pkg::LEN_NONE);
    assign cp_next  = {r_partial[14:0], i_byte[5:0]};
    assign held_inc = r_held + 3'd1;
    assign supp     = cp_next - utf8dec_pkg::SUPP_BASE;

    // Decode: next state and the tail units of this byte
    always_comb begin
        n_partial  = r_partial;
        n_expected = r_expected;
        n_held     = r_held;
        rep        = 2'd0;
        tcnt       = 2'd0;
        t0         = utf8dec_pkg::REPLACEMENT;
        t1         = utf8dec_pkg::REPLACEMENT;
        if (seq_open && is_cont) begin
            if (held_inc >= r_expected) begin
                n_partial  = '0;
                n_expected = utf8dec_pkg::LEN_NONE;
                n_held     = '0;
                if (cp_next < utf8dec_pkg::SUPP_BASE) begin
                    tcnt = 2'd1;
                    t0   = cp_next[15:0];
                end else begin
                    tcnt = 2'd2;
                    t0   = utf8dec_pkg::HIGH_SURR + {5'd0, supp[20:10]};
                    t1   = utf8dec_pkg::LOW_SURR | {6'd0, supp[9:0]};
                end
            end else begin
                n_partial = cp_next;
                n_held    = held_inc;
            end
        end else begin
            // interrupted sequence: one replacement per byte held
            if (seq_open) begin
                rep = r_held[1:0];
            end
            n_partial  = '0;
            n_expected = utf8dec_pkg::LEN_NONE;
            n_held     = '0;
            if (i_byte[7] == 1'b0) begin
                tcnt = 2'd1;
                t0   = {8'd0, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                n_partial  = {16'd0, i_byte[4:0]};
                n_expected = utf8dec_pkg::LEN_TWO;
                n_held     = 3'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_partial  = {17'd0, i_byte[3:0]};
                n_expected = utf8dec_pkg::LEN_THREE;
                n_held     = 3'd1;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_partial  = {18'd0, i_byte[2:0]};
                n_expected = utf8dec_pkg::LEN_FOUR;
                n_held     = 3'd1;
            end else begin
                tcnt = 2'd1;
            end
        end
    end

    // Pack replacements followed by tail units
    always_comb begin
        o_rec.cnt = {1'b0, rep} + {1'b0, tcnt};
        for (int k = 0; k < utf8dec_pkg::MAX_UNITS; k++) begin
            if (3'(k) < {1'b0, rep}) begin
                o_rec.units[k] = utf8dec_pkg::REPLACEMENT;
            end else if ((3'(k) - {1'b0, rep}) == 3'd0) begin
                o_rec.units[k] = t0;
            end else begin
                o_rec.units[k] = t1;
            end
        end
    end

    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;
    assign o_push  = accept && (o_rec.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial  <= '0;
            r_expected <= utf8dec_pkg::LEN_NONE;
            r_held     <= '0;
        end else if (accept) begin
            r_partial  <= n_partial;
            r_expected <= n_expected;
            r_held     <= n_held;
        end
    end

    // An open sequence always holds its lead and is never already full
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_expected != utf8dec_pkg::LEN_NONE) |-> (r_held != 3'd0 && r_held < r_expected))
        else $error("held count out of range for open sequence");

    a_closed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_expected == utf8dec_pkg::LEN_NONE) |-> (r_held == 3'd0 && r_partial == 21'd0))
        else $error("closed sequence left residue");

endmodule

// ===== src/utf8dec_queue.sv =====
`timescale 1ns / 1ps

module utf8dec_queue #(
    parameter int QDEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  utf8dec_pkg::t_dec_rec i_rec,
    output logic                  o_push_ready,
    output logic                  o_valid,
    output utf8dec_pkg::t_dec_rec o_rec,
    input  logic                  i_pop
);

    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(QDEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

    utf8dec_pkg::t_dec_rec r_mem [QDEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_valid      = (r_count != '0);
    assign o_rec        = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_IDX) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_IDX) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count overflow");

endmodule

// ===== src/utf8dec_back.sv =====
`timescale 1ns / 1ps

module utf8dec_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  utf8dec_pkg::t_dec_rec i_rec,
    output logic                  o_pop,
    output logic                  o_valid,
    output logic [15:0]           o_code_unit,
    output logic                  o_last_unit,
    input  logic                  i_ready
);

    logic [1:0]  r_idx;
    logic        r_valid;
    logic [15:0] r_code;
    logic        r_last;
    logic        load;
    logic        is_last;

    assign load    = i_valid && (!r_valid || i_ready);
    assign is_last = ({1'b0, r_idx} + 3'd1) == i_rec.cnt;
    assign o_pop   = load && is_last;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_code <= i_rec.units[r_idx];
            r_last <= is_last;
        end
    end

    // Slot within the head transaction record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (load) begin
            r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    assign o_valid     = r_valid;
    assign o_code_unit = r_code;
    assign o_last_unit = r_last;

    a_idx_in_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ({1'b0, r_idx} < i_rec.cnt))
        else $error("unit index beyond head record");

endmodule

// ===== src/utf8_to_utf16_stream_decoder_core.sv =====
`timescale 1ns / 1ps

// UTF-8 to UTF-16 stream decoder.
// i_byte: one UTF-8 byte per transaction (valid/ready). o_unit: one UTF-16
// code unit per transaction, last_unit set on the final unit caused by a byte.
// A byte is decoded in the cycle it is accepted; the units it causes go into
// a small record queue (QDEPTH records of up to four units each).
// A byte's first unit goes through the queue, then the output register.
// Throughput: one byte per cycle on input while the queue has room; one unit
// per cycle on output while the receiver is ready.
// Bytes that cause several units (surrogate pairs, replacements for a broken
// sequence) go out one unit at a time, the queue absorbs the burst.
// Bytes that only extend an open sequence produce no unit and no queue entry.
// Reset (synchronous, active low) closes any open sequence and empties the
// queue and the output register.
// When the receiver stalls, the output register holds; input stays ready
// until the queue fills, then i_byte.ready drops.
module utf8_to_utf16_stream_decoder_core #(
    parameter int QDEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    utf8dec_byte_if.sink   i_byte,
    utf8dec_unit_if.source o_unit
);

    logic                  push;
    logic                  push_ready;
    utf8dec_pkg::t_dec_rec push_rec;
    logic                  head_valid;
    utf8dec_pkg::t_dec_rec head_rec;
    logic                  pop;

    utf8dec_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_byte.valid),
        .i_byte       (i_byte.in_byte),
        .o_ready      (i_byte.ready),
        .o_push       (push),
        .o_rec        (push_rec),
        .i_push_ready (push_ready)
    );

    utf8dec_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_rec        (push_rec),
        .o_push_ready (push_ready),
        .o_valid      (head_valid),
        .o_rec        (head_rec),
        .i_pop        (pop)
    );

    utf8dec_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (head_valid),
        .i_rec       (head_rec),
        .o_pop       (pop),
        .o_valid     (o_unit.valid),
        .o_code_unit (o_unit.code_unit),
        .o_last_unit (o_unit.last_unit),
        .i_ready     (o_unit.ready)
    );

endmodule
